// File: design/fst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types and constants of the fifo queue with statistics.
// ----------------------------------------------------------------------------
package fst_pkg;

   localparam int DATA_W    = 32;
   localparam int DEPTH_DEF = 16;
   localparam int CNT_W_DEF = $clog2(DEPTH_DEF + 1);

   // request kinds
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

   // result status codes
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } fst_div_stat_type;

endpackage
`default_nettype wire

// File: design/fst_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fst_ram
// Entry storage of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fst_ram #(
   parameter  int DEPTH = fst_pkg::DEPTH_DEF,
   localparam int PTR_W = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [PTR_W-1:0]          wr_addr,
   input  wire logic [fst_pkg::DATA_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [PTR_W-1:0]          rd_addr,
   output logic      [fst_pkg::DATA_W-1:0] rd_data
);

   logic [fst_pkg::DATA_W-1:0] mem [DEPTH];
   logic [fst_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: design/fst_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fst_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module fst_div #(
   parameter int CNT_W = fst_pkg::CNT_W_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [fst_pkg::DATA_W-1:0]  dividend,
   input  wire logic [CNT_W-1:0]            divisor,
   output logic      [fst_pkg::DATA_W-1:0]  quotient,
   output fst_pkg::fst_div_stat_type        stat
);

   localparam int DW     = fst_pkg::DATA_W;
   localparam int STEP_W = $clog2(DW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [DW-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    rem_diff;
   logic              fits;
   logic [DW-1:0]     mag;

   assign rem_sh   = {rem_ff, quo_ff[DW-1]};
   assign fits     = rem_sh >= {1'b0, den_ff};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign mag      = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         neg_in  = dividend[DW-1];
         quo_in  = mag;
         rem_in  = '0;
         den_in  = divisor;
         step_in = STEP_W'(DW);
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DW-2:0], fits};
         rem_in  = fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign quotient  = neg_ff ? (~quo_ff + DW'(1)) : quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done at once");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff != '0 && step_ff <= STEP_W'(DW)))
      else $error("divider step count out of range");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == STEP_W'(1) && !start) |=> done_ff)
      else $error("divider missed its last step");

endmodule
`default_nettype wire

// File: design/fifo_queue_with_statistics.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_statistics
// Bounded fifo of signed 32-bit values with push, pop and search requests;
// each request returns status, popped value, found flag and queue statistics.
// ----------------------------------------------------------------------------
//  channel  dir  group                        contents
//  req      in   req_tvalid/tready/tdata/user  tuser: kind; tdata: value
//  rsp      out  rsp_tvalid/tready/tdata/user  tuser: status; tdata: results
//
//  a request walks over the entries through the single memory read port, then,
//  unless the queue is empty, runs the one-bit-per-cycle divider for the mean.
//  req_tready is high only while no request is in work.
//  a finished result waits in the output register; the next request is taken
//  meanwhile, and only its final result load waits for rsp_tready.
//  reset is synchronous; entry storage is not cleared.
// ----------------------------------------------------------------------------
module fifo_queue_with_statistics #(
   parameter  int DEPTH = fst_pkg::DEPTH_DEF,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int RSP_BITS = 7 * fst_pkg::DATA_W + 1 + CNT_W,
   localparam int RSP_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [fst_pkg::DATA_W-1:0]      req_tdata,  // value
   input  wire logic [fst_pkg::KIND_W-1:0]      req_tuser,  // kind
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // popped, found, count, total, mean, largest, smallest, head_value,
   // tail_value, zero fill
   output logic      [RSP_W-1:0]                rsp_tdata,
   output logic      [fst_pkg::STATUS_W-1:0]    rsp_tuser   // status
);

   localparam int DW = fst_pkg::DATA_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [fst_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [DW-1:0]                 val_ff, val_in;
   logic [fst_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [CNT_W-1:0]              occ_ff, occ_in;
   logic [PTR_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [DW-1:0]                 sum_ff, sum_in;
   logic [PTR_W-1:0]              iss_ptr_ff, iss_ptr_in;
   logic [CNT_W-1:0]              iss_left_ff, iss_left_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic                          skip_ff, skip_in;
   logic                          first_ff, first_in;
   logic [DW-1:0]                 popped_ff, popped_in;
   logic                          found_ff, found_in;
   logic [DW-1:0]                 max_ff, max_in;
   logic [DW-1:0]                 min_ff, min_in;
   logic [DW-1:0]                 head_ff, head_in;
   logic [DW-1:0]                 tail_ff, tail_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]              rsp_data_ff, rsp_data_in;
   logic [fst_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic                          acc;
   logic                          is_full;
   logic                          is_empty;
   logic                          push_ok;
   logic                          pop_ok;
   logic [PTR_W-1:0]              wr_ptr_nxt;
   logic [PTR_W-1:0]              rd_ptr_nxt;
   logic [PTR_W-1:0]              iss_ptr_nxt;
   logic                          rd_en;
   logic [DW-1:0]                 rd_data;
   logic                          walk_done;
   logic                          div_start;
   logic [DW-1:0]                 div_quot;
   fst_pkg::fst_div_stat_type     div_stat;
   logic                          out_free;
   logic [DW-1:0]                 mean;
   logic                          found_out;
   logic [CNT_W:0]                chk_ptr_sum;
   logic [CNT_W:0]                chk_ptr_wrap;

   assign acc      = req_tvalid && (state_ff == S_IDLE);
   assign is_full  = occ_ff == CNT_W'(DEPTH);
   assign is_empty = occ_ff == '0;
   assign push_ok  = acc && (req_tuser == fst_pkg::KIND_PUSH) && !is_full;
   assign pop_ok   = acc && (req_tuser == fst_pkg::KIND_POP) && !is_empty;

   assign wr_ptr_nxt  = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_nxt  = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign iss_ptr_nxt = (iss_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : iss_ptr_ff + PTR_W'(1);

   assign rd_en     = (state_ff == S_WALK) && (iss_left_ff != '0);
   assign walk_done = (iss_left_ff == '0) && !rd_vld_ff;
   assign div_start = (state_ff == S_WALK) && walk_done && !is_empty;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign mean      = is_empty ? '0 : div_quot;
   assign found_out = found_ff && (kind_ff == fst_pkg::KIND_SEARCH);

   fst_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (iss_ptr_ff),
      .rd_data (rd_data)
   );

   fst_div #(
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (occ_ff),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      occ_in        = occ_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      sum_in        = sum_ff;
      iss_ptr_in    = iss_ptr_ff;
      iss_left_in   = iss_left_ff;
      rd_vld_in     = rd_en;
      skip_in       = skip_ff;
      first_in      = first_ff;
      popped_in     = popped_ff;
      found_in      = found_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               kind_in   = req_tuser;
               val_in    = req_tdata;
               status_in = fst_pkg::STATUS_OK;
               if (req_tuser == fst_pkg::KIND_PUSH && is_full) begin
                  status_in = fst_pkg::STATUS_FULL;
               end else if ((req_tuser == fst_pkg::KIND_POP ||
                             req_tuser == fst_pkg::KIND_SEARCH) && is_empty) begin
                  status_in = fst_pkg::STATUS_EMPTY;
               end
               if (push_ok) begin
                  wr_ptr_in = wr_ptr_nxt;
                  occ_in    = occ_ff + CNT_W'(1);
                  sum_in    = sum_ff + req_tdata;
               end
               if (pop_ok) begin
                  rd_ptr_in = rd_ptr_nxt;
                  occ_in    = occ_ff - CNT_W'(1);
               end
               // walk starts at the old head; a pop reads its victim first
               iss_ptr_in  = rd_ptr_ff;
               iss_left_in = push_ok ? occ_ff + CNT_W'(1) : occ_ff;
               skip_in     = pop_ok;
               first_in    = 1'b1;
               popped_in   = '0;
               found_in    = 1'b0;
               max_in      = '0;
               min_in      = '0;
               head_in     = '0;
               tail_in     = '0;
               state_in    = S_WALK;
            end
         end
         S_WALK: begin
            if (rd_en) begin
               iss_ptr_in  = iss_ptr_nxt;
               iss_left_in = iss_left_ff - CNT_W'(1);
            end
            if (rd_vld_ff) begin
               if (skip_ff) begin
                  popped_in = rd_data;
                  sum_in    = sum_ff - rd_data;
                  skip_in   = 1'b0;
               end else begin
                  found_in = found_ff || (rd_data == val_ff);
                  tail_in  = rd_data;
                  if (first_ff) begin
                     first_in = 1'b0;
                     head_in  = rd_data;
                     max_in   = rd_data;
                     min_in   = rd_data;
                  end else begin
                     if ($signed(rd_data) > $signed(max_ff)) begin
                        max_in = rd_data;
                     end
                     if ($signed(rd_data) < $signed(min_ff)) begin
                        min_in = rd_data;
                     end
                  end
               end
            end
            if (walk_done) begin
               state_in = is_empty ? S_OUT : S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = RSP_W'({tail_ff, head_ff, min_ff, max_ff, mean,
                                       sum_ff, occ_ff, found_out, popped_ff});
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         sum_ff       <= '0;
         iss_left_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         sum_ff       <= sum_in;
         iss_left_ff  <= iss_left_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      iss_ptr_ff    <= iss_ptr_in;
      skip_ff       <= skip_in;
      first_ff      <= first_in;
      popped_ff     <= popped_in;
      found_ff      <= found_in;
      max_ff        <= max_in;
      min_ff        <= min_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // read pointer plus occupancy, wrapped, must land on the write pointer
   assign chk_ptr_sum  = (CNT_W + 1)'(rd_ptr_ff) + (CNT_W + 1)'(occ_ff);
   assign chk_ptr_wrap = (chk_ptr_sum >= (CNT_W + 1)'(DEPTH)) ?
                         chk_ptr_sum - (CNT_W + 1)'(DEPTH) : chk_ptr_sum;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy above depth");

   a_ptr_link: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (PTR_W'(chk_ptr_wrap) == wr_ptr_ff))
      else $error("pointers and occupancy disagree");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push_ok |=> (occ_ff == $past(occ_ff) + CNT_W'(1)))
      else $error("push did not grow occupancy");

   a_div_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> !div_stat.busy)
      else $error("divider running during walk");

endmodule
`default_nettype wire
